[rtl/cantor_pair_codec_defines.svh]
// ----------------------------------------------------------------------------
// cantor_pair_codec assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef CANTOR_PAIR_CODEC_DEFINES_SVH
`define CANTOR_PAIR_CODEC_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define CPC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cantor_pair_codec: assertion failed");
// next-cycle implication
`define CPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cantor_pair_codec: assertion failed");
`else
`define CPC_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define CPC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[rtl/cpc_pkg.sv]
// ----------------------------------------------------------------------------
// cpc_pkg
// Widths, operation codes and shared types of the Cantor pair codec.
// ----------------------------------------------------------------------------
package cpc_pkg;

  localparam int NUM_W   = 32;             // x, y
  localparam int PAIR_W  = 64;             // pair value
  localparam int RAD_W   = 68;             // 8p+1, padded to an even width
  localparam int ROOT_W  = RAD_W / 2;      // isqrt(8p+1)
  localparam int REM_W   = ROOT_W + 2;     // remainder <= 2*root
  localparam int W_W     = ROOT_W - 1;     // triangular index w
  localparam int SUM_W   = NUM_W + 1;      // x+y
  localparam int TRI_W   = 2 * SUM_W;      // s(s+1)/2 before adding y
  localparam int SQ_STAGES = ROOT_W;       // one root bit per stage

  typedef enum logic {
    FUNC_ENC = 1'b0,
    FUNC_DEC = 1'b1
  } func_t;

  // travels alongside the root pipeline: encode result is final by then
  typedef struct packed {
    func_t             func;
    logic              ovf;
    logic [PAIR_W-1:0] pair;
  } side_t;

endpackage

[rtl/cpc_isqrt.sv]
// ----------------------------------------------------------------------------
// cpc_isqrt
// Pipelined restoring integer square root, one root bit per stage, with
// remainder and a sideband carried alongside.
// ----------------------------------------------------------------------------
module cpc_isqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       adv,
  input  logic                       in_valid,
  input  logic [cpc_pkg::RAD_W-1:0]  in_rad,
  input  cpc_pkg::side_t             in_side,
  output logic                       out_valid,
  output logic [cpc_pkg::ROOT_W-1:0] out_root,
  output logic [cpc_pkg::REM_W-1:0]  out_rem,
  output cpc_pkg::side_t             out_side
);
  import cpc_pkg::*;

  logic              vld_r  [SQ_STAGES];
  logic [REM_W-1:0]  rem_r  [SQ_STAGES];
  logic [ROOT_W-1:0] root_r [SQ_STAGES];
  logic [RAD_W-1:0]  rad_r  [SQ_STAGES];
  side_t             side_r [SQ_STAGES];

  for (genvar k = 0; k < SQ_STAGES; k++) begin : g_stage
    logic              vld_in;
    logic [REM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [RAD_W-1:0]  rad_in;
    side_t             side_in;
    logic [REM_W+1:0]  cur;
    logic [REM_W+1:0]  trial;
    logic [REM_W+1:0]  diff;
    logic              ge;
    logic [REM_W-1:0]  rem_nxt;
    logic [ROOT_W-1:0] root_nxt;
    logic [RAD_W-1:0]  rad_nxt;

    if (k == 0) begin : g_first
      assign vld_in  = in_valid;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = in_rad;
      assign side_in = in_side;
    end else begin : g_rest
      assign vld_in  = vld_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign rad_in  = rad_r[k-1];
      assign side_in = side_r[k-1];
    end

    // bring down the next two radicand bits, try (4*root + 1)
    assign cur   = {rem_in, rad_in[RAD_W-1 -: 2]};
    assign trial = {{(REM_W-ROOT_W){1'b0}}, root_in, 2'b01};
    assign ge    = (cur >= trial);
    assign diff  = cur - trial;

    assign rem_nxt  = ge ? diff[REM_W-1:0] : cur[REM_W-1:0];
    assign root_nxt = {root_in[ROOT_W-2:0], ge};
    assign rad_nxt  = {rad_in[RAD_W-3:0], 2'b00};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (adv) begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k]  <= rem_nxt;
        root_r[k] <= root_nxt;
        rad_r[k]  <= rad_nxt;
        side_r[k] <= side_in;
      end
    end
  end

  assign out_valid = vld_r[SQ_STAGES-1];
  assign out_root  = root_r[SQ_STAGES-1];
  assign out_rem   = rem_r[SQ_STAGES-1];
  assign out_side  = side_r[SQ_STAGES-1];

endmodule

[rtl/cantor_pair_codec.sv]
// ----------------------------------------------------------------------------
// cantor_pair_codec
// Cantor pairing encode (x,y -> pair) and decode (pair -> x,y), exact
// integers, saturating with an overflow flag.
// ----------------------------------------------------------------------------
//  channel | ports                                     | handshake
//  --------+-------------------------------------------+-------------------
//  input   | in_func in_x in_y in_pair_in              | in_valid / in_stall
//  result  | out_pair_out out_x_out out_y_out          | out_valid / out_stall
//          | out_overflow                              |
//
//  One transaction per cycle unless the result channel stalls. Stages in order:
//  input register, three multiply stages, 34 square-root stages (one root bit
//  each), two fix-up stages, the last being the output register.
//  rst_n is synchronous and clears only the valid bits.
//  While the output register holds an untaken transaction the whole pipeline
//  freezes and in_stall is high; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
`include "cantor_pair_codec_defines.svh"

module cantor_pair_codec (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_func,
  input  logic [cpc_pkg::NUM_W-1:0]  in_x,
  input  logic [cpc_pkg::NUM_W-1:0]  in_y,
  input  logic [cpc_pkg::PAIR_W-1:0] in_pair_in,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [cpc_pkg::PAIR_W-1:0] out_pair_out,
  output logic [cpc_pkg::NUM_W-1:0]  out_x_out,
  output logic [cpc_pkg::NUM_W-1:0]  out_y_out,
  output logic                       out_overflow
);
  import cpc_pkg::*;

  logic adv;

  // front: input register
  logic              f0_vld_r;
  func_t             f0_func_r;
  logic [NUM_W-1:0]  f0_x_r;
  logic [NUM_W-1:0]  f0_y_r;
  logic [PAIR_W-1:0] f0_p_r;

  // front: split s(s+1)/2 into a*b, one factor halved
  logic [SUM_W-1:0]  s_nxt;
  logic [SUM_W:0]    s1_nxt;
  logic [SUM_W-1:0]  a_nxt;
  logic [SUM_W-1:0]  b_nxt;
  logic              f1_vld_r;
  func_t             f1_func_r;
  logic [SUM_W-1:0]  f1_a_r;
  logic [SUM_W-1:0]  f1_b_r;
  logic [NUM_W-1:0]  f1_y_r;
  logic [RAD_W-1:0]  f1_rad_r;

  // front: partial products
  logic [2*NUM_W-1:0] pp_nxt;
  logic [NUM_W:0]     cross_nxt;
  logic               f2_vld_r;
  func_t              f2_func_r;
  logic [2*NUM_W-1:0] f2_pp_r;
  logic [NUM_W:0]     f2_cross_r;
  logic               f2_hh_r;
  logic [NUM_W-1:0]   f2_y_r;
  logic [RAD_W-1:0]   f2_rad_r;

  // front: triangular number
  logic [TRI_W-1:0]  t_nxt;
  logic              f3_vld_r;
  func_t             f3_func_r;
  logic [TRI_W-1:0]  f3_t_r;
  logic [NUM_W-1:0]  f3_y_r;
  logic [RAD_W-1:0]  f3_rad_r;

  // encode finish, enters the root pipeline as sideband
  logic [TRI_W:0]    enc_sum;
  logic              enc_ovf;
  side_t             ent_side;

  logic              sq_vld;
  logic [ROOT_W-1:0] sq_root;
  logic [REM_W-1:0]  sq_rem;
  side_t             sq_side;

  // back: y = (rem + (r even ? 2r-1 : 0)) / 8, w = (r-1)/2
  logic [REM_W:0]    corr_nxt;
  logic [REM_W:0]    y8_nxt;
  logic [ROOT_W-1:0] rm1_nxt;
  logic              p1_vld_r;
  side_t             p1_side_r;
  logic [W_W-1:0]    p1_w_r;
  logic [W_W-1:0]    p1_y_r;

  logic [W_W-1:0]    x_nxt;
  logic [PAIR_W-1:0] pair_nxt;
  logic [NUM_W-1:0]  xo_nxt;
  logic [NUM_W-1:0]  yo_nxt;
  logic              ovf_nxt;

  logic              out_vld_r;
  logic [PAIR_W-1:0] out_pair_r;
  logic [NUM_W-1:0]  out_x_r;
  logic [NUM_W-1:0]  out_y_r;
  logic              out_ovf_r;

  assign adv      = !(out_vld_r && out_stall);
  assign in_stall = !rst_n || !adv;

  // ---------------- stage 0 ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f0_vld_r <= 1'b0;
    end else if (adv) begin
      f0_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f0_func_r <= func_t'(in_func);
      f0_x_r    <= in_x;
      f0_y_r    <= in_y;
      f0_p_r    <= in_pair_in;
    end
  end

  // ---------------- stage 1 ----------------
  assign s_nxt  = {1'b0, f0_x_r} + {1'b0, f0_y_r};
  assign s1_nxt = {1'b0, s_nxt} + {{SUM_W{1'b0}}, 1'b1};
  assign a_nxt  = s_nxt[0] ? s_nxt : {1'b0, s_nxt[SUM_W-1:1]};
  assign b_nxt  = s_nxt[0] ? s1_nxt[SUM_W:1] : s1_nxt[SUM_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_vld_r <= 1'b0;
    end else if (adv) begin
      f1_vld_r <= f0_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f1_func_r <= f0_func_r;
      f1_a_r    <= a_nxt;
      f1_b_r    <= b_nxt;
      f1_y_r    <= f0_y_r;
      f1_rad_r  <= {1'b0, f0_p_r, 3'b001};
    end
  end

  // ---------------- stage 2 ----------------
  assign pp_nxt    = (2*NUM_W)'(f1_a_r[NUM_W-1:0]) * (2*NUM_W)'(f1_b_r[NUM_W-1:0]);
  assign cross_nxt = (f1_a_r[NUM_W] ? {1'b0, f1_b_r[NUM_W-1:0]} : '0)
                   + (f1_b_r[NUM_W] ? {1'b0, f1_a_r[NUM_W-1:0]} : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f2_vld_r <= 1'b0;
    end else if (adv) begin
      f2_vld_r <= f1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f2_func_r  <= f1_func_r;
      f2_pp_r    <= pp_nxt;
      f2_cross_r <= cross_nxt;
      f2_hh_r    <= f1_a_r[NUM_W] & f1_b_r[NUM_W];
      f2_y_r     <= f1_y_r;
      f2_rad_r   <= f1_rad_r;
    end
  end

  // ---------------- stage 3 ----------------
  assign t_nxt = {1'b0, f2_hh_r, {(2*NUM_W){1'b0}}}
               + {1'b0, f2_cross_r, {NUM_W{1'b0}}}
               + {2'b00, f2_pp_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f3_vld_r <= 1'b0;
    end else if (adv) begin
      f3_vld_r <= f2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f3_func_r <= f2_func_r;
      f3_t_r    <= t_nxt;
      f3_y_r    <= f2_y_r;
      f3_rad_r  <= f2_rad_r;
    end
  end

  // encode result settles here and rides along the root pipeline
  assign enc_sum       = {1'b0, f3_t_r} + {{(TRI_W+1-NUM_W){1'b0}}, f3_y_r};
  assign enc_ovf       = |enc_sum[TRI_W:PAIR_W];
  assign ent_side.func = f3_func_r;
  assign ent_side.ovf  = enc_ovf;
  assign ent_side.pair = enc_ovf ? '1 : enc_sum[PAIR_W-1:0];

  cpc_isqrt u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (f3_vld_r),
    .in_rad    (f3_rad_r),
    .in_side   (ent_side),
    .out_valid (sq_vld),
    .out_root  (sq_root),
    .out_rem   (sq_rem),
    .out_side  (sq_side)
  );

  // ---------------- back stage 1 ----------------
  // r = 2w+1 leaves rem = 8y; r = 2w+2 leaves rem = 8y - (2r-1)
  assign corr_nxt = sq_root[0] ? '0 : ({2'b00, sq_root, 1'b0} - {{REM_W{1'b0}}, 1'b1});
  assign y8_nxt   = {1'b0, sq_rem} + corr_nxt;
  assign rm1_nxt  = sq_root - {{(ROOT_W-1){1'b0}}, 1'b1};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
    end else if (adv) begin
      p1_vld_r <= sq_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_side_r <= sq_side;
      p1_w_r    <= rm1_nxt[ROOT_W-1:1];
      p1_y_r    <= y8_nxt[W_W+2:3];
    end
  end

  // ---------------- back stage 2: output register ----------------
  assign x_nxt = p1_w_r - p1_y_r;

  always_comb begin
    pair_nxt = '0;
    xo_nxt   = '0;
    yo_nxt   = '0;
    ovf_nxt  = 1'b0;
    case (p1_side_r.func)
      FUNC_ENC: begin
        pair_nxt = p1_side_r.pair;
        ovf_nxt  = p1_side_r.ovf;
      end
      FUNC_DEC: begin
        xo_nxt  = x_nxt[NUM_W] ? '1 : x_nxt[NUM_W-1:0];
        yo_nxt  = p1_y_r[NUM_W] ? '1 : p1_y_r[NUM_W-1:0];
        ovf_nxt = x_nxt[NUM_W] | p1_y_r[NUM_W];
      end
      default: begin
        pair_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= p1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_pair_r <= pair_nxt;
      out_x_r    <= xo_nxt;
      out_y_r    <= yo_nxt;
      out_ovf_r  <= ovf_nxt;
    end
  end

  assign out_valid    = out_vld_r;
  assign out_pair_out = out_pair_r;
  assign out_x_out    = out_x_r;
  assign out_y_out    = out_y_r;
  assign out_overflow = out_ovf_r;

  // ---------------- assertions ----------------
  `CPC_ASSERT_NEXT(a_accept_lands, clk, rst_n, in_valid && !in_stall, f0_vld_r)
  `CPC_ASSERT_IMPLY(a_dec_y_le_w, clk, rst_n, p1_vld_r && p1_side_r.func == FUNC_DEC, p1_y_r <= p1_w_r)
  `CPC_ASSERT_IMPLY(a_pair_excl, clk, rst_n, out_vld_r && out_pair_r != '0, out_x_r == '0 && out_y_r == '0)
  `CPC_ASSERT_IMPLY(a_enc_sat, clk, rst_n, out_vld_r && out_ovf_r && out_x_r == '0 && out_y_r == '0, out_pair_r == '1)

endmodule
